// ===== design/fdn_pkg.sv =====
// ============================================================================
// fdn_pkg
// Shared constants, tables and arithmetic helpers for the twelve-line
// feedback delay network reverberator.
// ============================================================================
package fdn_pkg;

    localparam int LINES         = 12;
    localparam int LINE_W        = 4;
    localparam int CMD_W         = 2;
    localparam int SAMPLE_W      = 24;
    localparam int COEF_W        = 16;
    localparam int MAX_DELAY_DEF = 2048;

    // Internal arithmetic widths
    localparam int SUM_W  = SAMPLE_W + 4;
    localparam int SLOT_W = SAMPLE_W + 3;
    localparam int MIX_W  = SLOT_W + 4;
    localparam int PROD_W = COEF_W + 1 + SLOT_W;
    localparam int DIV_W  = 34;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GAIN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABSORB = 2'd2;

    // Prime line lengths
    localparam int LINE_LEN [LINES] = '{
        601, 691, 773, 839, 919, 997, 1061, 1093, 1129, 1151, 1171, 1187
    };

    // Line whose filtered value lands in each slot (inverse routing)
    localparam logic [LINE_W-1:0] SLOT_SRC [LINES] = '{
        4'd2, 4'd7, 4'd8, 4'd10, 4'd6, 4'd5, 4'd1, 4'd9, 4'd0, 4'd11, 4'd3, 4'd4
    };

    localparam logic [COEF_W-1:0] GAIN_RST [LINES] = '{
        16'd64631, 16'd64496, 16'd64374, 16'd64275, 16'd64157, 16'd64041,
        16'd63946, 16'd63899, 16'd63845, 16'd63813, 16'd63783, 16'd63760
    };

    localparam logic [COEF_W-1:0] ABSORB_RST [LINES] = '{
        16'd63915, 16'd63676, 16'd63459, 16'd63285, 16'd63074, 16'd62869,
        16'd62702, 16'd62618, 16'd62524, 16'd62467, 16'd62415, 16'd62374
    };

    // Floor division by 24: shift by 3, then divide by 3 through a
    // reciprocal multiply on a biased, non-negative operand.
    localparam logic signed [DIV_W-1:0] DIV_BIAS = 34'sd1610612736;
    localparam logic [31:0]             RECIP3   = 32'hAAAAAAAB;
    localparam logic signed [31:0]      DIV_OFFS = 32'sd536870912;

    function automatic logic [31:0] div24_bias(input logic signed [DIV_W-1:0] n);
        logic signed [DIV_W-1:0] m;
        m = (n >>> 3) + DIV_BIAS;
        return m[31:0];
    endfunction

    function automatic logic signed [31:0] div24_finish(input logic [63:0] p);
        logic signed [31:0] q;
        q = $signed({1'b0, p[63:33]});
        return q - DIV_OFFS;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [DIV_W-1:0] v);
        logic signed [DIV_W-1:0] hi;
        logic signed [DIV_W-1:0] lo;
        hi = DIV_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
        lo = -hi - DIV_W'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_W-1:0];
        end
        if (v < lo)
        begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== design/feedback_delay_network_reverb_top.sv =====
// ============================================================================
// feedback_delay_network_reverb_top
// Twelve-line feedback delay network reverberator with Householder mixing.
// ============================================================================
// Flow: a sample word passes through a divide, the read pass, a divide, the
//   write pass, a divide and the output step; a coefficient load or unused
//   command goes straight to the output step. One word is in flight at a time.
// Input: a new word is taken only after the last one leaves the output step;
//   the single delay memory port (one read per line, then one write per line)
//   and the shared divide unit serve one word at a time. A stalled output holds
//   the sequencer in its output step and keeps the input blocked.
// Reset: positions, filter states and wrap flags clear; coefficient tables load
//   their decay defaults. The delay memory is not swept: a per-line wrap flag
//   makes never-written entries read as zero.
module feedback_delay_network_reverb_top
    import fdn_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           cmd,
    input  logic [LINE_W-1:0]          line,
    input  logic [COEF_W-1:0]          coef_value,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    localparam int PW    = $clog2(MAX_DELAY);
    localparam int AW    = LINE_W + PW;
    localparam int DEPTH = LINES * (2 ** PW);

    // Sequencer:
    //   read pass  RD -> R1 -> R2 per line (memory read, filter multiply, update)
    //   write pass P2 -> W per line (gain multiply, feedback write-back)
    //   DV0..DV2 is the shared divide-by-24 unit, returning to ret_reg.
    typedef enum logic [3:0] {
        S_IDLE, S_DV0, S_DV1, S_DV2, S_RD, S_R1, S_R2, S_P2, S_W, S_OUT
    } state_t;

    state_t                     state_reg;
    state_t                     ret_reg;
    logic [LINE_W-1:0]          idx_reg;
    logic [PW-1:0]              pos_reg [LINES];
    logic [LINES-1:0]           wrapped_reg;
    logic signed [SAMPLE_W-1:0] fs_reg [LINES];
    logic [COEF_W-1:0]          gain_reg [LINES];
    logic [COEF_W-1:0]          absorb_reg [LINES];
    logic signed [SAMPLE_W-1:0] xq_reg;
    logic signed [SLOT_W-1:0]   t_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [MIX_W-1:0]    mix_reg;
    logic signed [SAMPLE_W-1:0] d_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DIV_W-1:0]    div_n_reg;
    logic [31:0]                div_u_reg;
    logic [63:0]                div_p_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    // Delay memory: line i owns the rows {i, position}
    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] mem_q_reg;

    logic [LINE_W-1:0]          fs_idx;
    logic signed [SAMPLE_W-1:0] fs_sel;
    logic signed [SAMPLE_W-1:0] d_now;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [SAMPLE_W+1:0] f_wide;
    logic signed [SAMPLE_W-1:0] f_now;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SLOT_W-1:0]   slot;
    logic signed [DIV_W-1:0]    fb_wide;
    logic [PW-1:0]              pos_cur;
    logic [PW-1:0]              pos_next;
    logic                       pos_wrap;
    logic [AW-1:0]              addr;
    logic                       last_line;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_comb
    begin
        // The filter state is read at the line itself in the read pass and
        // at the slot's source line in the write pass: one read port.
        fs_idx    = (state_reg == S_P2) ? SLOT_SRC[idx_reg] : idx_reg;
        fs_sel    = fs_reg[fs_idx];
        d_now     = wrapped_reg[idx_reg] ? mem_q_reg : '0;
        diff      = (SAMPLE_W+1)'(fs_sel) - (SAMPLE_W+1)'(d_now);
        rnd       = (prod_reg + PROD_W'(32768)) >>> COEF_W;
        f_wide    = (SAMPLE_W+2)'(d_reg) + rnd[SAMPLE_W+1:0];
        f_now     = f_wide[SAMPLE_W-1:0];
        sum_next  = sum_reg + SUM_W'(f_now);
        slot      = SLOT_W'(fs_sel) - t_reg;
        fb_wide   = DIV_W'(xq_reg) + rnd[DIV_W-1:0];
        pos_cur   = pos_reg[idx_reg];
        pos_wrap  = (int'(pos_cur) + 1 >= LINE_LEN[idx_reg]);
        pos_next  = pos_wrap ? '0 : pos_cur + PW'(1);
        addr      = {idx_reg, pos_cur};
        last_line = (idx_reg == LINE_W'(LINES - 1));
    end

    // Memory port: one synchronous read or one write per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            mem_q_reg <= mem[addr];
        end
        if (state_reg == S_W)
        begin
            mem[addr] <= sat_sample(fb_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            idx_reg        <= '0;
            wrapped_reg    <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                pos_reg[i]    <= '0;
                fs_reg[i]     <= '0;
                gain_reg[i]   <= GAIN_RST[i];
                absorb_reg[i] <= ABSORB_RST[i];
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_reg <= '0;
                        priority if (cmd == CMD_SAMPLE)
                        begin
                            div_n_reg <= (DIV_W'(sample_in) <<< 1) + DIV_W'(12);
                            ret_reg   <= S_RD;
                            idx_reg   <= '0;
                            sum_reg   <= '0;
                            mix_reg   <= '0;
                            state_reg <= S_DV0;
                        end
                        else if (cmd == CMD_GAIN)
                        begin
                            if (line < LINE_W'(LINES))
                            begin
                                gain_reg[line] <= coef_value;
                            end
                            state_reg <= S_OUT;
                        end
                        else if (cmd == CMD_ABSORB)
                        begin
                            if (line < LINE_W'(LINES))
                            begin
                                absorb_reg[line] <= coef_value;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DV0:
                begin
                    div_u_reg <= div24_bias(div_n_reg);
                    state_reg <= S_DV1;
                end
                S_DV1:
                begin
                    div_p_reg <= 64'(div_u_reg) * 64'(RECIP3);
                    state_reg <= S_DV2;
                end
                S_DV2:
                begin
                    // Drop the quotient where the caller expects it
                    priority case (ret_reg)
                        S_RD:    xq_reg  <= SAMPLE_W'(div24_finish(div_p_reg));
                        S_P2:    t_reg   <= SLOT_W'(div24_finish(div_p_reg));
                        default: res_reg <= sat_sample(DIV_W'(div24_finish(div_p_reg)));
                    endcase
                    state_reg <= ret_reg;
                end
                S_RD:
                begin
                    state_reg <= S_R1;
                end
                S_R1:
                begin
                    d_reg     <= d_now;
                    prod_reg  <= $signed({1'b0, absorb_reg[idx_reg]}) * diff;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    fs_reg[idx_reg] <= f_now;
                    sum_reg         <= sum_next;
                    if (last_line)
                    begin
                        div_n_reg <= (DIV_W'(sum_next) <<< 2) + DIV_W'(12);
                        ret_reg   <= S_P2;
                        idx_reg   <= '0;
                        state_reg <= S_DV0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + LINE_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_P2:
                begin
                    prod_reg  <= $signed({1'b0, gain_reg[idx_reg]}) * slot;
                    mix_reg   <= idx_reg[0] ? mix_reg - MIX_W'(slot)
                                            : mix_reg + MIX_W'(slot);
                    state_reg <= S_W;
                end
                S_W:
                begin
                    pos_reg[idx_reg] <= pos_next;
                    if (pos_wrap)
                    begin
                        wrapped_reg[idx_reg] <= 1'b1;
                    end
                    if (last_line)
                    begin
                        div_n_reg <= (DIV_W'(mix_reg) <<< 1) + DIV_W'(12);
                        ret_reg   <= S_OUT;
                        idx_reg   <= '0;
                        state_reg <= S_DV0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + LINE_W'(1);
                        state_reg <= S_P2;
                    end
                end
                S_OUT:
                begin
                    // Hold the result until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= res_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < LINE_W'(LINES))
        else $error("line index out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W |-> int'(pos_reg[idx_reg]) < LINE_LEN[idx_reg])
        else $error("delay position beyond line length");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word while busy");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result word raised outside output step");

endmodule

// ===== dv/feedback_delay_network_reverb_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// feedback_delay_network_reverb_top_test
// Drives sample and coefficient-load words into the reverberator, predicts
// every output word from a bit-true model of the twelve-line network, and
// compares each returned word in order. Both sides idle in random bursts.
// ============================================================================
module feedback_delay_network_reverb_top_test
    import fdn_pkg::*;
();

    localparam int MAXD          = MAX_DELAY_DEF;
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_WORDS  = 1580;
    localparam int STALL_CYCLES  = 1500;

    // Line routing: line i lands in slot ROUTE[i]
    localparam int ROUTE [LINES] = '{8, 6, 0, 10, 11, 5, 4, 1, 2, 7, 3, 9};
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int S_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int S_MIN = -(1 << (SAMPLE_W - 1));

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [CMD_W-1:0]           cmd;
    logic [LINE_W-1:0]          line;
    logic [COEF_W-1:0]          coef_value;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    feedback_delay_network_reverb_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .line       (line),
        .coef_value (coef_value),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    // Predictor state: mirrors the network's memories
    longint echo_mem [LINES*MAXD];
    int     tap_pos  [LINES];
    longint lowpass  [LINES];
    longint gain     [LINES];
    longint damp     [LINES];

    logic signed [SAMPLE_W-1:0] expected_out [$];
    int  errors;
    int  words_sent;
    int  words_seen;
    int  samples_sent;
    int  loads_sent;
    bit  stim_done;
    bit  calm;        // final stretch with no idling
    bit  hold_sink;   // long receiver stall request

    typedef struct
    {
        logic [CMD_W-1:0]           op;
        logic [LINE_W-1:0]          idx;
        logic [COEF_W-1:0]          coef;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         known;
        logic signed [SAMPLE_W-1:0] want;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Floor division, then round-to-nearest with ties toward +inf
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint round_div(longint n, longint d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic longint clamp24(longint v);
        if (v > S_MAX)
        begin
            return S_MAX;
        end
        if (v < S_MIN)
        begin
            return S_MIN;
        end
        return v;
    endfunction

    task automatic reset_network();
        for (int i = 0; i < LINES*MAXD; i++)
        begin
            echo_mem[i] = 0;
        end
        for (int i = 0; i < LINES; i++)
        begin
            tap_pos[i] = 0;
            lowpass[i] = 0;
            gain[i]    = GAIN_RST[i];
            damp[i]    = ABSORB_RST[i];
        end
    endtask

    // Advance the network model by one word and return its output
    function automatic logic signed [SAMPLE_W-1:0] reverb_step(row_t w);
        longint slot [LINES];
        longint total;
        longint refl;
        longint mix;
        longint x;
        longint fb;
        total = 0;
        mix   = 0;
        if (w.op == CMD_GAIN || w.op == CMD_ABSORB)
        begin
            if (w.idx < LINES)
            begin
                if (w.op == CMD_GAIN)
                begin
                    gain[w.idx] = w.coef;
                end
                else
                begin
                    damp[w.idx] = w.coef;
                end
            end
            return '0;
        end
        if (w.op != CMD_SAMPLE)
        begin
            return '0;
        end
        x = w.smp;
        for (int i = 0; i < LINES; i++)
        begin
            lowpass[i] = round_div(damp[i] * lowpass[i]
                + (65536 - damp[i]) * echo_mem[i*MAXD + tap_pos[i]], 65536);
            total += lowpass[i];
        end
        refl = round_div(2 * total, LINES);
        for (int i = 0; i < LINES; i++)
        begin
            slot[ROUTE[i]] = lowpass[i] - refl;
        end
        for (int i = 0; i < LINES; i++)
        begin
            mix = (i % 2) ? mix - slot[i] : mix + slot[i];
        end
        for (int i = 0; i < LINES; i++)
        begin
            fb = round_div(x, LINES) + round_div(gain[i] * slot[i], 65536);
            echo_mem[i*MAXD + tap_pos[i]] = clamp24(fb);
            tap_pos[i] = (tap_pos[i] + 1 >= LINE_LEN[i]) ? 0 : tap_pos[i] + 1;
        end
        return clamp24(round_div(mix, LINES));
    endfunction

    // Now and then idle for a random burst; drop valid while idling
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    // Present one word and hold it until accepted; queue its prediction
    task automatic send_word(row_t w);
        logic signed [SAMPLE_W-1:0] pred;
        cmd        <= w.op;
        line       <= w.idx;
        coef_value <= w.coef;
        sample_in  <= w.smp;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pred = reverb_step(w);
        if (w.known && pred !== w.want)
        begin
            $display("%0t: table row disagrees with prediction: %0d vs %0d",
                $realtime, w.want, pred);
            errors++;
        end
        expected_out.push_back(w.known ? w.want : pred);
        words_sent++;
        if (w.op == CMD_SAMPLE)
        begin
            samples_sent++;
        end
        else
        begin
            loads_sent++;
        end
        @(negedge clk);
    endtask

    function automatic row_t mk(logic [CMD_W-1:0] op, int idx, int coef, int smp,
        bit known, int want);
        row_t r;
        r.op    = op;
        r.idx   = idx[LINE_W-1:0];
        r.coef  = coef[COEF_W-1:0];
        r.smp   = smp[SAMPLE_W-1:0];
        r.known = known;
        r.want  = want[SAMPLE_W-1:0];
        return r;
    endfunction

    // Mostly samples with occasional coefficient loads and stray commands
    function automatic row_t random_word();
        int pick;
        int s;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: s = S_MAX;
            1: s = S_MIN;
            2: s = $urandom_range(0, 255) - 128;
            default: s = $urandom;
        endcase
        if (pick < 88)
        begin
            return mk(CMD_SAMPLE, $urandom_range(0, 15), $urandom, s, 0, 0);
        end
        else if (pick < 93)
        begin
            return mk(CMD_GAIN, $urandom_range(0, 15),
                $urandom_range(0, 1) ? $urandom_range(58000, 65535) : $urandom, s, 0, 0);
        end
        else if (pick < 98)
        begin
            return mk(CMD_ABSORB, $urandom_range(0, 15), $urandom, s, 0, 0);
        end
        return mk(CMD_UNUSED, $urandom_range(0, 15), $urandom, s, 0, 0);
    endfunction

    // Sender: directed table, then random words
    initial
    begin
        row_t table_rows [$];
        in_valid   = 1'b0;
        cmd        = CMD_SAMPLE;
        line       = '0;
        coef_value = '0;
        sample_in  = '0;
        rst_n      = 1'b0;
        errors     = 0;
        words_sent = 0;
        samples_sent = 0;
        loads_sent = 0;
        stim_done  = 1'b0;
        calm       = 1'b0;
        hold_sink  = 1'b0;
        reset_network();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fresh network: empty lines give silence until the first echo returns
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, S_MAX, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, S_MIN, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 15, 16'hFFFF, 0, 1, 0));
        // Loads, out-of-range indexes and the unused command all return zero
        table_rows.push_back(mk(CMD_GAIN, 0, 65535, 0, 1, 0));
        table_rows.push_back(mk(CMD_GAIN, 11, 0, 0, 1, 0));
        table_rows.push_back(mk(CMD_ABSORB, 0, 0, S_MAX, 1, 0));
        table_rows.push_back(mk(CMD_ABSORB, 11, 65535, 0, 1, 0));
        table_rows.push_back(mk(CMD_GAIN, 12, 1234, 0, 1, 0));
        table_rows.push_back(mk(CMD_ABSORB, 15, 65535, 0, 1, 0));
        table_rows.push_back(mk(CMD_UNUSED, 5, 65535, S_MIN, 1, 0));
        table_rows.push_back(mk(CMD_UNUSED, 15, 0, S_MAX, 1, 0));
        table_rows.push_back(mk(CMD_GAIN, 5, 32768, -1, 1, 0));
        table_rows.push_back(mk(CMD_ABSORB, 6, 1, 1, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, -1, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, 1, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, 6, 1, 0));
        table_rows.push_back(mk(CMD_SAMPLE, 0, 0, -6, 1, 0));
        foreach (table_rows[k])
        begin
            maybe_idle();
            send_word(table_rows[k]);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 300)
            begin
                hold_sink = 1'b1;   // receiver backs off; keep offering words
            end
            if (n == RANDOM_WORDS - 200)
            begin
                calm = 1'b1;
            end
            maybe_idle();
            send_word(random_word());
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random backpressure plus one long stall
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each returned word with the oldest prediction
    initial
    begin
        logic signed [SAMPLE_W-1:0] want;
        words_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                words_seen++;
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected word, actual %0d", $realtime, sample_out);
                    errors++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (sample_out !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d actual %0d",
                            $realtime, want, sample_out);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= IDLE_LIMIT)
            begin
                $display("timeout: %0d words pending", expected_out.size());
                $display("FAIL feedback_delay_network_reverb_top");
                $finish;
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        wait (expected_out.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d words: %0d samples, %0d loads or stray commands, %0d checked.",
            words_sent, samples_sent, loads_sent, words_seen);
        if (errors == 0)
        begin
            $display("PASS feedback_delay_network_reverb_top");
        end
        else
        begin
            $display("FAIL feedback_delay_network_reverb_top");
        end
        $finish;
    end

endmodule
